// ===== hdl/dpwm4_pkg.sv =====
// dpwm4_pkg: shared widths, register kinds and defaults for the four-channel dithered pwm
// no dependencies

package dpwm4_pkg;

    localparam int CHANNELS        = 4;
    localparam int PERIOD_DEF      = 100;
    localparam int DITHER_BITS_DEF = 5;

    localparam int BASE_W      = 7;
    localparam int FRAC_W      = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 7;
    localparam int CH_SEL_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [BASE_W-1:0] COMPARE_MAX = {BASE_W{1'b1}};

    // register index bit 0 picks the kind within a channel pair
    localparam logic REG_KIND_BASE = 1'b0;
    localparam logic REG_KIND_FRAC = 1'b1;

    typedef logic [BASE_W-1:0] base_t;
    typedef logic [FRAC_W-1:0] frac_t;

endpackage

// ===== hdl/dithered_pwm_four_channel.sv =====
// dithered_pwm_four_channel: four-channel dithered pwm, one result per tick; depends on dpwm4_pkg
// an accepted tick transaction's result is registered and shows on the m_ channel in the next cycle
// throughput: one tick transaction per cycle while m_ready takes each result, set by the single state update per tick;
// the output register refills in the same cycle its result is taken
// reset (aresetn low, synchronous): counters, compares, config registers and result valid clear
// configuration writes are always accepted and reach a compare only at a wrap that reloads it

module dithered_pwm_four_channel
    import dpwm4_pkg::*;
#(
    parameter int PERIOD      = PERIOD_DEF,
    parameter int DITHER_BITS = DITHER_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // tick channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_count_enable,

    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_pwm_out0,
    output logic                   m_pwm_out1,
    output logic                   m_pwm_out2,
    output logic                   m_pwm_out3,
    output logic                   m_period_end,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // width of the period counter, and the common width for the duty compare
    localparam int PCNT_W = $clog2(PERIOD);
    localparam int CMP_W  = (PCNT_W > BASE_W) ? PCNT_W : BASE_W;
    // common width for the dither count against the fraction register
    localparam int DW     = (DITHER_BITS > FRAC_W) ? DITHER_BITS : FRAC_W;

    localparam logic [PCNT_W-1:0]      PERIOD_LAST = PCNT_W'(PERIOD - 1);
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT   = CFG_INDEX_W'(2 * CHANNELS);

    // state
    logic [PCNT_W-1:0]      period_count_reg;
    logic [DITHER_BITS-1:0] dither_count_reg   [CHANNELS];
    base_t                  active_compare_reg [CHANNELS];

    // configuration registers
    base_t                  base_duty_reg      [CHANNELS];
    frac_t                  dither_frac_reg    [CHANNELS];

    // result register
    logic                   m_valid_reg;
    logic [CHANNELS-1:0]    pwm_reg;
    logic                   period_end_reg;

    // next values
    logic [PCNT_W-1:0]      period_count_next;
    logic [DITHER_BITS-1:0] dither_count_next  [CHANNELS];
    base_t                  active_compare_next[CHANNELS];
    logic [CHANNELS-1:0]    pwm_next;
    logic                   period_end_next;

    logic                   in_xact;
    logic                   tick;
    logic                   wrap;
    logic [BASE_W:0]        base_inc;

    // the result register frees up in the same cycle its transaction completes
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xact   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign tick = in_xact && s_count_enable;
    assign wrap = tick && (period_count_reg >= PERIOD_LAST);

    always_comb begin
        period_count_next = period_count_reg;
        if (tick) begin
            if (wrap) begin
                period_count_next = '0;
            end else begin
                period_count_next = period_count_reg + PCNT_W'(1);
            end
        end
    end

    // outputs use the count before this tick's advance
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            pwm_next[c] = (CMP_W'(period_count_reg) < CMP_W'(active_compare_reg[c]));
        end
        period_end_next = wrap;
    end

    // dither step per channel, only taken at a wrap
    always_comb begin
        base_inc = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            dither_count_next[c]   = dither_count_reg[c] + DITHER_BITS'(1);
            active_compare_next[c] = active_compare_reg[c];
            base_inc               = {1'b0, base_duty_reg[c]} + (BASE_W+1)'(1);
            if (DW'(dither_count_next[c]) == DW'(dither_frac_reg[c])) begin
                active_compare_next[c] = base_duty_reg[c];
            end else if (dither_count_next[c] == '0) begin
                // base+1 saturates at the top of the compare range
                active_compare_next[c] = base_inc[BASE_W] ? COMPARE_MAX : base_inc[BASE_W-1:0];
            end
        end
    end

    // counter and dither state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                dither_count_reg[c]   <= '0;
                active_compare_reg[c] <= '0;
            end
        end else begin
            period_count_reg <= period_count_next;
            if (wrap) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    dither_count_reg[c]   <= dither_count_next[c];
                    active_compare_reg[c] <= active_compare_next[c];
                end
            end
        end
    end

    // configuration decode: index 2c is base duty, 2c+1 is fraction, the rest ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                base_duty_reg[c]   <= '0;
                dither_frac_reg[c] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (cfg_index < REG_COUNT)) begin
            unique case (cfg_index[0])
                REG_KIND_BASE: begin
                    base_duty_reg[cfg_index[CH_SEL_W:1]] <= cfg_data[BASE_W-1:0];
                end
                REG_KIND_FRAC: begin
                    dither_frac_reg[cfg_index[CH_SEL_W:1]] <= cfg_data[FRAC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xact) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact) begin
            pwm_reg        <= pwm_next;
            period_end_reg <= period_end_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pwm_out0   = pwm_reg[0];
    assign m_pwm_out1   = pwm_reg[1];
    assign m_pwm_out2   = pwm_reg[2];
    assign m_pwm_out3   = pwm_reg[3];
    assign m_period_end = period_end_reg;

`ifndef SYNTH
    // counter never leaves its period
    assert property (@(posedge aclk) disable iff (!aresetn)
        period_count_reg <= PERIOD_LAST)
        else $error("period counter out of range");

    // a tick on the last count wraps to zero and flags the period end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xact && s_count_enable && period_count_reg == PERIOD_LAST)
        |=> (period_count_reg == '0) && m_valid && m_period_end)
        else $error("wrap not taken");

    // no tick, no movement
    assert property (@(posedge aclk) disable iff (!aresetn)
        !tick |=> $stable(period_count_reg))
        else $error("period counter moved without a tick");

    // a held tick never reports a period end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xact && !s_count_enable) |=> m_valid && !m_period_end)
        else $error("period end on a held tick");
`endif

endmodule

// ===== tb/dithered_pwm_checker.sv =====
`timescale 1ns / 1ps
// dithered_pwm_checker: watches the tick, result and configuration channels,
// predicts every pwm result and compares it field by field
// depends on dpwm4_pkg

module dithered_pwm_checker
    import dpwm4_pkg::*;
#(
    parameter int PERIOD      = PERIOD_DEF,
    parameter int DITHER_BITS = DITHER_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_count_enable,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_pwm_out0,
    input  logic                   m_pwm_out1,
    input  logic                   m_pwm_out2,
    input  logic                   m_pwm_out3,
    input  logic                   m_period_end,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   end_of_test,
    output int                     awaiting,
    output int                     flaws
);

    localparam int DITHER_MASK = (1 << DITHER_BITS) - 1;
    localparam int REPORT_CAP  = 40;

    typedef struct packed {
        logic [CHANNELS-1:0] pwm;
        logic                period_end;
    } pwm_result_t;

    // shadow copy of the block state and its registers
    int    tick_pos;
    int    dither_pos   [CHANNELS];
    int    live_compare [CHANNELS];
    base_t base_reg     [CHANNELS];
    frac_t frac_reg     [CHANNELS];

    pwm_result_t pwm_expected [$];
    logic        leftovers_done;

    initial begin
        flaws = 0;
    end

    task automatic flag_mismatch(input string what);
        flaws++;
        if (flaws <= REPORT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    function automatic void clear_shadow();
        tick_pos = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            dither_pos[c]   = 0;
            live_compare[c] = 0;
            base_reg[c]     = '0;
            frac_reg[c]     = '0;
        end
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        int ch;
        if (idx < 2 * CHANNELS) begin
            ch = idx >> 1;
            if (idx[0] == REG_KIND_BASE) begin
                base_reg[ch] = val[BASE_W-1:0];
            end else begin
                frac_reg[ch] = val[FRAC_W-1:0];
            end
        end
    endfunction

    // outputs come from the count before the advance; a wrap steps every dither counter
    function automatic pwm_result_t predict_tick(input logic en);
        pwm_result_t r;
        int          bumped;
        r.period_end = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            r.pwm[c] = (tick_pos < live_compare[c]);
        end
        if (en) begin
            if (tick_pos >= PERIOD - 1) begin
                tick_pos     = 0;
                r.period_end = 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    dither_pos[c] = (dither_pos[c] + 1) & DITHER_MASK;
                    bumped = int'(base_reg[c]) + 1;
                    if (bumped > int'(COMPARE_MAX)) begin
                        bumped = int'(COMPARE_MAX);
                    end
                    if (dither_pos[c] == int'(frac_reg[c])) begin
                        live_compare[c] = int'(base_reg[c]);
                    end else if (dither_pos[c] == 0) begin
                        live_compare[c] = bumped;
                    end
                end
            end else begin
                tick_pos++;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        pwm_result_t want;
        pwm_result_t got;
        if (!aresetn) begin
            clear_shadow();
            pwm_expected.delete();
            leftovers_done <= 1'b0;
            awaiting       <= 0;
        end else begin
            // a result is registered before it leaves, so it never leaves in its own tick's cycle; pop first
            if (m_valid && m_ready) begin
                got.pwm        = {m_pwm_out3, m_pwm_out2, m_pwm_out1, m_pwm_out0};
                got.period_end = m_period_end;
                if (pwm_expected.size() == 0) begin
                    flag_mismatch("result transaction with nothing expected");
                end else begin
                    want = pwm_expected.pop_front();
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (got.pwm[c] !== want.pwm[c]) begin
                            flag_mismatch($sformatf("pwm_out%0d is %b, expected %b",
                                                    c, got.pwm[c], want.pwm[c]));
                        end
                    end
                    if (got.period_end !== want.period_end) begin
                        flag_mismatch($sformatf("period_end is %b, expected %b",
                                                got.period_end, want.period_end));
                    end
                end
            end
            // a tick in the same cycle as a write still sees the old registers
            if (s_valid && s_ready) begin
                pwm_expected.push_back(predict_tick(s_count_enable));
            end
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
            end
            if (end_of_test && !leftovers_done) begin
                leftovers_done <= 1'b1;
                if (pwm_expected.size() != 0) begin
                    flag_mismatch($sformatf("%0d expected results never arrived",
                                            pwm_expected.size()));
                end
            end
            awaiting <= pwm_expected.size();
        end
    end

endmodule

// ===== tb/tb_dithered_pwm_four_channel.sv =====
`timescale 1ns / 1ps
// tb_dithered_pwm_four_channel: clock, reset and stimulus for the four-channel dithered pwm,
// with random idling on both channels; depends on dpwm4_pkg, the block and dithered_pwm_checker

module tb_dithered_pwm_four_channel;
    import dpwm4_pkg::*;

    // eight random phases of mostly real ticks; each phase is reprogrammed from idle
    // and the dither counters carry on from one phase to the next
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int CHUNK          = 50;
    localparam int NUM_REGS       = 2 * CHANNELS;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // directed tick pattern, lsb first: holds at count zero, a run of ticks,
    // holds in mid period, then two more ticks
    localparam logic [24:0] DIRECTED_EN = 25'b11_000_111111111111111_00000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_count_enable;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_pwm_out0;
    logic                   m_pwm_out1;
    logic                   m_pwm_out2;
    logic                   m_pwm_out3;
    logic                   m_period_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic end_of_test;
    logic steady;       // high for stretches with no idling on either side
    int   awaiting;
    int   flaws;
    int   quiet_cycles;

    // register values for the next programming pass
    base_t                 base_set  [CHANNELS];
    logic [CFG_DATA_W-1:0] frac_word [CHANNELS];

    dithered_pwm_four_channel i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_count_enable (s_count_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_out0     (m_pwm_out0),
        .m_pwm_out1     (m_pwm_out1),
        .m_pwm_out2     (m_pwm_out2),
        .m_pwm_out3     (m_pwm_out3),
        .m_period_end   (m_period_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    dithered_pwm_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_count_enable (s_count_enable),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pwm_out0     (m_pwm_out0),
        .m_pwm_out1     (m_pwm_out1),
        .m_pwm_out2     (m_pwm_out2),
        .m_pwm_out3     (m_pwm_out3),
        .m_period_end   (m_period_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .end_of_test    (end_of_test),
        .awaiting       (awaiting),
        .flaws          (flaws)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // idle cycles before the next transaction on either side
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // bases lean on the edges: zero, last count of the period, one past it, the top code
    function automatic base_t draw_base();
        case ($urandom_range(0, 5))
            0:       return base_t'(0);
            1:       return base_t'(PERIOD_DEF - 1);
            2:       return base_t'(PERIOD_DEF);
            3:       return COMPARE_MAX;
            default: return base_t'($urandom_range(0, 2 ** BASE_W - 1));
        endcase
    endfunction

    // the two bits above the fraction are don't-care and get random values
    function automatic logic [CFG_DATA_W-1:0] draw_frac_word();
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom_range(0, 2 ** CFG_DATA_W - 1));
        case ($urandom_range(0, 3))
            0:       w[FRAC_W-1:0] = '0;
            1:       w[FRAC_W-1:0] = '1;
            default: ;
        endcase
        return w;
    endfunction

    // one tick transaction; valid stays up when the next one follows with no gap
    task automatic issue_tick(input logic en);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_count_enable <= en;
        do @(posedge aclk); while (!s_ready);
    endtask

    // one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // writes every register, and optionally some out-of-range indexes that must be ignored
    task automatic program_channels(input bit with_bad);
        for (int c = 0; c < CHANNELS; c++) begin
            write_reg(CFG_INDEX_W'((c << 1) | REG_KIND_BASE), CFG_DATA_W'(base_set[c]));
            write_reg(CFG_INDEX_W'((c << 1) | REG_KIND_FRAC), frac_word[c]);
        end
        if (with_bad) begin
            write_reg(CFG_INDEX_W'(NUM_REGS), '1);
            write_reg('1, '1);
            write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, 2 ** CFG_INDEX_W - 1)),
                      CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // drop the tick valid and wait until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random back-pressure, one draw per result transaction
    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // watchdog: too long without any transaction on any channel ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_count_enable <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        end_of_test    <= 1'b0;
        steady         <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: saturating base+1, zero base, last count, base past the period,
        // fraction extremes with the spare data bits set, and ignored indexes
        base_set  = '{COMPARE_MAX, base_t'(0), base_t'(PERIOD_DEF - 1), base_t'(PERIOD_DEF)};
        frac_word = '{7'h7F, 7'h00, 7'h60, 7'h10};
        program_channels(1'b1);
        for (int k = 0; k < 25; k++) begin
            issue_tick(DIRECTED_EN[k]);
        end
        drain();

        // random phases, reprogrammed only while the block is idle
        for (int ph = 1; ph <= PHASES; ph++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (ph == 1) begin
                    // everything back to the reset values
                    base_set[c]  = base_t'(0);
                    frac_word[c] = '0;
                end else if (ph == PHASES) begin
                    // everything at the top
                    base_set[c]  = COMPARE_MAX;
                    frac_word[c] = '1;
                end else begin
                    base_set[c]  = draw_base();
                    frac_word[c] = draw_frac_word();
                end
            end
            program_channels(ph[0]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % CHUNK == 0) begin
                    steady <= ($urandom_range(0, 3) == 0);
                end
                // mostly real ticks so the period wraps often, with the odd hold
                issue_tick($urandom_range(0, 15) != 0);
            end
            drain();
        end

        end_of_test <= 1'b1;
        repeat (3) @(posedge aclk);
        if (flaws == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
